FILE: rtl/cwb_pkg.sv
// Package for the cursor word buffer: sizes, opcodes, status codes,
// the command and result beat types and the controller state type.
// No dependencies.
package cwb_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = 7;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_DELETE   = 3'd1;
    localparam logic [2:0] OP_LEFT     = 3'd2;
    localparam logic [2:0] OP_RIGHT    = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;
    localparam logic [2:0] OP_READ_OUT = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BEGIN = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]           opcode;
        logic [WORD_BITS-1:0] word_code;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [WORD_BITS-1:0] word_out;
        logic [CNT_BITS-1:0]  position;
        logic [CNT_BITS-1:0]  length;
        logic                 last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PUT_WORD,
        S_SHIFT_DN,
        S_READOUT
    } state_t;

endpackage

FILE: rtl/cwb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cwb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cursor_word_buffer_top.sv
// Cursor word buffer: an ordered row of words with a length and a cursor,
// edited by one command beat at a time. Uses cwb_pkg and cwb_ram.
//
//   channel   ports                 handshake
//   command   cmd                   taken when start is high and busy is low
//   result    result                one beat per cycle in which strobe is high
//
// Left, right, clear, unknown opcodes, rejected edits and edits at the end of
// the row are done in the idle state; the result follows in the next cycle.
// An insert before the end shifts the tail up (S_SHIFT_UP) and writes the word
// (S_PUT_WORD); a delete before the end shifts it down (S_SHIFT_DN), one word
// moved per cycle through the word RAM, with one write and one registered read
// port. A read out gives one word per cycle via the RAM and result registers.
// Reset empties the row and sets the cursor to zero; the RAM needs no clearing.
module cursor_word_buffer_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cwb_pkg::cmd_t cmd,
    output logic          strobe,
    output cwb_pkg::res_t result
);

    cwb_pkg::state_t                   state_reg, state_next;
    logic [cwb_pkg::CNT_BITS-1:0]      count_reg, count_next;
    logic [cwb_pkg::CNT_BITS-1:0]      cursor_reg, cursor_next;
    logic [cwb_pkg::ADDR_BITS-1:0]     mv_dst_reg, mv_dst_next;
    logic [cwb_pkg::WORD_BITS-1:0]     word_reg, word_next;
    cwb_pkg::res_t                     res_reg, res_next;
    logic                              strobe_reg, strobe_next;

    logic                              ram_we;
    logic [cwb_pkg::ADDR_BITS-1:0]     ram_waddr;
    logic [cwb_pkg::WORD_BITS-1:0]     ram_wdata;
    logic [cwb_pkg::ADDR_BITS-1:0]     ram_raddr;
    logic [cwb_pkg::WORD_BITS-1:0]     ram_rdata;

    logic                              accept;
    logic                              up_more;
    logic                              dn_more;
    logic                              ro_more;
    logic                              fin;
    logic [1:0]                        st;

    localparam logic [cwb_pkg::CNT_BITS-1:0] CAP = cwb_pkg::CNT_BITS'(cwb_pkg::CAPACITY);

    cwb_ram #(
        .WIDTH(cwb_pkg::WORD_BITS),
        .DEPTH(cwb_pkg::CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign busy   = (state_reg != cwb_pkg::S_IDLE);
    assign accept = start && !busy;
    assign strobe = strobe_reg;
    assign result = res_reg;

    assign up_more = (cwb_pkg::CNT_BITS'(mv_dst_reg) > (cursor_reg + 1'b1));
    assign dn_more = ((cwb_pkg::CNT_BITS'(mv_dst_reg) + 2'd2) < count_reg);
    assign ro_more = ((cwb_pkg::CNT_BITS'(mv_dst_reg) + 1'b1) != count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cwb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        cwb_pkg::OP_INSERT:
                        begin
                            if (count_reg < CAP && cursor_reg != count_reg)
                            begin
                                state_next = cwb_pkg::S_SHIFT_UP;
                            end
                        end
                        cwb_pkg::OP_DELETE:
                        begin
                            if (cursor_reg != '0 && cursor_reg != count_reg)
                            begin
                                state_next = cwb_pkg::S_SHIFT_DN;
                            end
                        end
                        cwb_pkg::OP_READ_OUT:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = cwb_pkg::S_READOUT;
                            end
                        end
                        default:
                        begin
                            state_next = cwb_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            cwb_pkg::S_SHIFT_UP:
            begin
                if (!up_more)
                begin
                    state_next = cwb_pkg::S_PUT_WORD;
                end
            end
            cwb_pkg::S_PUT_WORD:
            begin
                state_next = cwb_pkg::S_IDLE;
            end
            cwb_pkg::S_SHIFT_DN:
            begin
                if (!dn_more)
                begin
                    state_next = cwb_pkg::S_IDLE;
                end
            end
            cwb_pkg::S_READOUT:
            begin
                if (!ro_more)
                begin
                    state_next = cwb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cwb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        mv_dst_next = mv_dst_reg;
        word_next   = word_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = mv_dst_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = mv_dst_reg;
        fin         = 1'b0;
        st          = cwb_pkg::ST_OK;

        case (state_reg)
            cwb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        cwb_pkg::OP_INSERT:
                        begin
                            word_next = cmd.word_code;
                            if (count_reg >= CAP)
                            begin
                                fin = 1'b1;
                                st  = cwb_pkg::ST_FULL;
                            end
                            else if (cursor_reg == count_reg)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = cwb_pkg::ADDR_BITS'(cursor_reg);
                                ram_wdata   = cmd.word_code;
                                count_next  = count_reg + 1'b1;
                                cursor_next = cursor_reg + 1'b1;
                                fin         = 1'b1;
                            end
                            else
                            begin
                                ram_raddr   = cwb_pkg::ADDR_BITS'(count_reg - 1'b1);
                                mv_dst_next = cwb_pkg::ADDR_BITS'(count_reg);
                            end
                        end
                        cwb_pkg::OP_DELETE:
                        begin
                            if (cursor_reg == '0)
                            begin
                                fin = 1'b1;
                                st  = cwb_pkg::ST_BEGIN;
                            end
                            else if (cursor_reg == count_reg)
                            begin
                                count_next  = count_reg - 1'b1;
                                cursor_next = cursor_reg - 1'b1;
                                fin         = 1'b1;
                            end
                            else
                            begin
                                ram_raddr   = cwb_pkg::ADDR_BITS'(cursor_reg);
                                mv_dst_next = cwb_pkg::ADDR_BITS'(cursor_reg - 1'b1);
                            end
                        end
                        cwb_pkg::OP_LEFT:
                        begin
                            fin = 1'b1;
                            if (cursor_reg == '0)
                            begin
                                st = cwb_pkg::ST_BEGIN;
                            end
                            else
                            begin
                                cursor_next = cursor_reg - 1'b1;
                            end
                        end
                        cwb_pkg::OP_RIGHT:
                        begin
                            fin = 1'b1;
                            if (cursor_reg >= count_reg)
                            begin
                                st = cwb_pkg::ST_END;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                        cwb_pkg::OP_CLEAR:
                        begin
                            fin         = 1'b1;
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        cwb_pkg::OP_READ_OUT:
                        begin
                            if (count_reg == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                ram_raddr   = '0;
                                mv_dst_next = '0;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            cwb_pkg::S_SHIFT_UP:
            begin
                ram_we = 1'b1;
                if (up_more)
                begin
                    ram_raddr   = mv_dst_reg - 2'd2;
                    mv_dst_next = mv_dst_reg - 1'b1;
                end
            end
            cwb_pkg::S_PUT_WORD:
            begin
                ram_we      = 1'b1;
                ram_waddr   = cwb_pkg::ADDR_BITS'(cursor_reg);
                ram_wdata   = word_reg;
                count_next  = count_reg + 1'b1;
                cursor_next = cursor_reg + 1'b1;
                fin         = 1'b1;
            end
            cwb_pkg::S_SHIFT_DN:
            begin
                ram_we = 1'b1;
                if (dn_more)
                begin
                    ram_raddr   = mv_dst_reg + 2'd2;
                    mv_dst_next = mv_dst_reg + 1'b1;
                end
                else
                begin
                    count_next  = count_reg - 1'b1;
                    cursor_next = cursor_reg - 1'b1;
                    fin         = 1'b1;
                end
            end
            cwb_pkg::S_READOUT:
            begin
                strobe_next       = 1'b1;
                res_next.status   = cwb_pkg::ST_OK;
                res_next.word_out = ram_rdata;
                res_next.position = cwb_pkg::CNT_BITS'(mv_dst_reg);
                res_next.length   = count_reg;
                res_next.last     = !ro_more;
                if (ro_more)
                begin
                    ram_raddr   = mv_dst_reg + 1'b1;
                    mv_dst_next = mv_dst_reg + 1'b1;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase

        if (fin)
        begin
            strobe_next       = 1'b1;
            res_next.status   = st;
            res_next.word_out = '0;
            res_next.position = cursor_next;
            res_next.length   = count_next;
            res_next.last     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cwb_pkg::S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_dst_reg <= mv_dst_next;
        word_reg   <= word_next;
        res_reg    <= res_next;
    end

`ifndef SYNTH
    a_cursor_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond the end of the row");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("word count beyond capacity");

    a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cwb_pkg::S_READOUT |-> !ram_we)
        else $error("RAM write during read out");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.opcode == cwb_pkg::OP_LEFT || cmd.opcode == cwb_pkg::OP_RIGHT
                   || cmd.opcode == cwb_pkg::OP_CLEAR) |=> strobe && result.last && !busy)
        else $error("cursor or clear command gave no result in the next cycle");

    a_shift_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cwb_pkg::S_PUT_WORD |=> strobe && !busy)
        else $error("insert finished without a result");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for cursor_word_buffer_top: directed edits, then random
// fill, mixed and drain phases, each result beat checked against an in-bench row model.
// Depends on cwb_pkg and the cursor_word_buffer_top RTL.
module tb;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 80;

    typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

    typedef struct {
        logic [2:0]    op;
        logic [31:0]   word;
        bit            typed;
        cwb_pkg::res_t want;
    } edit_row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    cwb_pkg::cmd_t cmd_beat;
    logic          strobe;
    cwb_pkg::res_t res_beat;

    bit            typed_on;
    cwb_pkg::res_t typed_res;

    logic [cwb_pkg::WORD_BITS-1:0] row_words [cwb_pkg::CAPACITY];
    int row_len;
    int row_cur;

    cwb_pkg::res_t expected_beats[$];
    edit_row_t directed_rows[$];

    int fail_count;
    int cmds_taken;
    int beats_checked;
    int full_rejects;
    int peak_len;
    int quiet_cycles;

    cursor_word_buffer_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd_beat),
        .strobe (strobe),
        .result (res_beat)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic int apply_edit(input cwb_pkg::cmd_t c);
        cwb_pkg::res_t r;
        int i;
        r = '0;
        r.status = cwb_pkg::ST_OK;
        r.last = 1'b1;
        case (c.opcode)
            cwb_pkg::OP_INSERT:
                if (row_len >= cwb_pkg::CAPACITY)
                begin
                    r.status = cwb_pkg::ST_FULL;
                    full_rejects++;
                end
                else
                begin
                    for (i = row_len; i > row_cur; i--)
                        row_words[i] = row_words[i-1];
                    row_words[row_cur] = c.word_code;
                    row_len++;
                    row_cur++;
                end
            cwb_pkg::OP_DELETE:
                if (row_cur == 0)
                    r.status = cwb_pkg::ST_BEGIN;
                else
                begin
                    for (i = row_cur - 1; i + 1 < row_len; i++)
                        row_words[i] = row_words[i+1];
                    row_len--;
                    row_cur--;
                end
            cwb_pkg::OP_LEFT:
                if (row_cur == 0)
                    r.status = cwb_pkg::ST_BEGIN;
                else
                    row_cur--;
            cwb_pkg::OP_RIGHT:
                if (row_cur >= row_len)
                    r.status = cwb_pkg::ST_END;
                else
                    row_cur++;
            cwb_pkg::OP_CLEAR:
            begin
                row_len = 0;
                row_cur = 0;
            end
            cwb_pkg::OP_READ_OUT:
                if (row_len > 0)
                begin
                    for (i = 0; i < row_len; i++)
                    begin
                        r.word_out = row_words[i];
                        r.position = cwb_pkg::CNT_BITS'(i);
                        r.length = cwb_pkg::CNT_BITS'(row_len);
                        r.last = (i + 1 == row_len);
                        expected_beats.push_back(r);
                    end
                    return row_len;
                end
            default: ;
        endcase
        if (row_len > peak_len)
            peak_len = row_len;
        r.position = cwb_pkg::CNT_BITS'(row_cur);
        r.length = cwb_pkg::CNT_BITS'(row_len);
        expected_beats.push_back(r);
        return 1;
    endfunction

    task automatic check_beat(input cwb_pkg::res_t got);
        cwb_pkg::res_t want;
        if (expected_beats.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result beat %h", got));
            return;
        end
        want = expected_beats.pop_front();
        beats_checked++;
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.word_out !== want.word_out)
            report_mismatch($sformatf("word_out %h, expected %h", got.word_out, want.word_out));
        if (got.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      got.position, want.position));
        if (got.length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask

    always @(posedge clk)
    begin
        int n;
        if (rst_n && start && !busy)
        begin
            cmds_taken++;
            n = apply_edit(cmd_beat);
            if (typed_on && n == 1)
                expected_beats[expected_beats.size()-1] = typed_res;
        end
        if (rst_n && strobe)
            check_beat(res_beat);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("cursor_word_buffer_top test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [2:0] pick_op(input phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
            begin
                if (r < 80) return cwb_pkg::OP_INSERT;
                if (r < 88) return cwb_pkg::OP_LEFT;
                if (r < 93) return cwb_pkg::OP_RIGHT;
                if (r < 97) return cwb_pkg::OP_READ_OUT;
            end
            PH_MIX:
            begin
                if (r < 30) return cwb_pkg::OP_INSERT;
                if (r < 50) return cwb_pkg::OP_DELETE;
                if (r < 65) return cwb_pkg::OP_LEFT;
                if (r < 80) return cwb_pkg::OP_RIGHT;
                if (r < 85) return cwb_pkg::OP_CLEAR;
                if (r < 93) return cwb_pkg::OP_READ_OUT;
            end
            default:
            begin
                if (r < 60) return cwb_pkg::OP_DELETE;
                if (r < 85) return cwb_pkg::OP_RIGHT;
                if (r < 90) return cwb_pkg::OP_LEFT;
                if (r < 95) return cwb_pkg::OP_READ_OUT;
                return cwb_pkg::OP_INSERT;
            end
        endcase
        return ($urandom_range(0, 1) != 0) ? OP_SPARE7 : OP_SPARE6;
    endfunction

    function automatic edit_row_t mk_row(input logic [2:0] op, input logic [31:0] word,
                                         input bit typed, input logic [1:0] st,
                                         input int pos, input int len);
        edit_row_t row;
        row.op = op;
        row.word = word;
        row.typed = typed;
        row.want = '0;
        row.want.status = st;
        row.want.position = cwb_pkg::CNT_BITS'(pos);
        row.want.length = cwb_pkg::CNT_BITS'(len);
        row.want.last = 1'b1;
        return row;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_edit(input logic [2:0] op, input logic [31:0] word, input int gap,
                             input bit typed, input cwb_pkg::res_t want);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        cmd_beat.opcode = op;
        cmd_beat.word_code = word;
        typed_on = typed;
        typed_res = want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        phase_t ph;
        int k;
        rst_n = 1'b0;
        start = 1'b0;
        cmd_beat = '0;
        typed_on = 1'b0;
        typed_res = '0;
        row_len = 0;
        row_cur = 0;
        fail_count = 0;
        cmds_taken = 0;
        beats_checked = 0;
        full_rejects = 0;
        peak_len = 0;
        quiet_cycles = 0;

        directed_rows.push_back(mk_row(cwb_pkg::OP_DELETE,   32'h0000_0000, 1,
                                       cwb_pkg::ST_BEGIN, 0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_LEFT,     32'hFFFF_FFFF, 1,
                                       cwb_pkg::ST_BEGIN, 0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_RIGHT,    32'h0000_0000, 1,
                                       cwb_pkg::ST_END,   0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_READ_OUT, 32'hFFFF_FFFF, 1,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(OP_SPARE6,            32'h0000_0000, 1,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(OP_SPARE7,            32'hFFFF_FFFF, 1,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_INSERT,   32'h0000_0000, 1,
                                       cwb_pkg::ST_OK,    1, 1));
        directed_rows.push_back(mk_row(cwb_pkg::OP_INSERT,   32'hFFFF_FFFF, 1,
                                       cwb_pkg::ST_OK,    2, 2));
        directed_rows.push_back(mk_row(cwb_pkg::OP_LEFT,     32'h0000_0000, 1,
                                       cwb_pkg::ST_OK,    1, 2));
        directed_rows.push_back(mk_row(cwb_pkg::OP_INSERT,   32'hA5A5_A5A5, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_READ_OUT, 32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_RIGHT,    32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_RIGHT,    32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_LEFT,     32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_DELETE,   32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_LEFT,     32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_DELETE,   32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_RIGHT,    32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_INSERT,   32'h8000_0001, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_INSERT,   32'h7FFF_FFFE, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_READ_OUT, 32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_DELETE,   32'h0000_0000, 0,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_CLEAR,    32'h0000_0000, 1,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_READ_OUT, 32'h0000_0000, 1,
                                       cwb_pkg::ST_OK,    0, 0));
        directed_rows.push_back(mk_row(cwb_pkg::OP_INSERT,   32'h1234_5678, 1,
                                       cwb_pkg::ST_OK,    1, 1));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_edit(directed_rows[i].op, directed_rows[i].word, pick_gap(),
                      directed_rows[i].typed, directed_rows[i].want);

        // The fill phase runs the row into the full case, the drain phase empties it
        // again back to back with no idle cycles.
        for (k = 0; k < 205; k++)
        begin
            ph = (k < 90) ? PH_FILL : (k < 150) ? PH_MIX : PH_DRAIN;
            send_edit(pick_op(ph), $urandom(), (ph == PH_DRAIN) ? 0 : pick_gap(), 0, '0);
        end
        start = 1'b0;
        typed_on = 1'b0;

        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));

        $display("Run covered %0d commands and %0d result beats, peak length %0d,",
                 cmds_taken, beats_checked, peak_len);
        $display("%0d inserts rejected on a full row, %0d mismatches.",
                 full_rejects, fail_count);
        if (fail_count == 0)
            $display("cursor_word_buffer_top test passed");
        else
            $display("cursor_word_buffer_top test failed");
        $finish;
    end
endmodule
